// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int TAG_WIDTH      = 16;
    localparam int PRIORITY_WIDTH = 4;
    localparam int OCC_WIDTH      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SERVE  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        command_t                  command;
        logic [TAG_WIDTH-1:0]      entry_tag;
        logic [PRIORITY_WIDTH-1:0] priority_req;
    } req_word_t;

    typedef struct packed {
        status_t                   status;
        logic [TAG_WIDTH-1:0]      served_tag;
        logic [PRIORITY_WIDTH-1:0] served_priority;
        logic [OCC_WIDTH-1:0]      occupancy;
    } rsp_word_t;

    // One stored queue entry.
    typedef struct packed {
        logic [TAG_WIDTH-1:0]      tag;
        logic [PRIORITY_WIDTH-1:0] prio;
    } entry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic   insert;
        logic   serve;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// behind the new entry, shifts left on serve.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Hold this slot on insert when it is occupied and its priority does not exceed the new one.
    assign keep  = occupied && (entry_reg.prio <= ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                // First slot past the kept prefix takes the new entry.
                entry_next = left_keep ? ctrl.new_entry : left_entry;
            end
        end
        else if (ctrl.serve)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded, stable priority queue built as a shifting chain of sorted cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one command word:
//   insert a tagged entry, or serve the head entry. rsp channel
//   (rsp_valid/rsp_ready/rsp_data) returns exactly one result word per
//   command: status, the served entry (zero unless served) and occupancy.
//   Lower priority values leave first; equal priorities leave in arrival
//   order. An insert into a full queue is dropped and reported as full; a
//   serve on an empty queue reports empty.
//   The result word is registered and is valid in the cycle after the
//   command word is accepted. Throughput: one command per cycle while the
//   result channel is not stalled. Every cell compares its priority against
//   the new entry in parallel and shifts by one slot in the same cycle.
//   Stall: the result sits in an output register; a new command is taken
//   whenever that register is empty or being drained in the same cycle.
//   Reset: clears the entry count and the output valid flag; cell contents
//   are not cleared, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  spq_pkg::req_word_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output spq_pkg::rsp_word_t rsp_data
);
    import spq_pkg::*;

    logic [OCC_WIDTH-1:0] count_reg;
    logic [OCC_WIDTH-1:0] count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    rsp_word_t            rsp_data_reg;
    rsp_word_t            rsp_data_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;

    entry_t cell_entry [QUEUE_DEPTH];
    logic   cell_keep  [QUEUE_DEPTH];
    logic   cell_occ   [QUEUE_DEPTH];

    // Take a new word when the output register is free or draining.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign is_full   = (count_reg == OCC_WIDTH'(QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);

    // Broadcast the command to the chain; drop full inserts and empty serves.
    assign ctrl.insert    = accept && (req_data.command == CMD_INSERT) && !is_full;
    assign ctrl.serve     = accept && (req_data.command == CMD_SERVE) && !is_empty;
    assign ctrl.new_entry = '{tag: req_data.entry_tag, prio: req_data.priority_req};

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            entry_t left_entry;
            entry_t right_entry;
            logic   left_keep;

            assign cell_occ[g] = (count_reg > OCC_WIDTH'(g));

            if (g == 0)
            begin : g_head
                // The empty prefix ahead of the head counts as kept, so an
                // unkept head takes the new entry.
                assign left_entry = '0;
                assign left_keep  = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[g-1];
                assign left_keep  = cell_keep[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_mid
                assign right_entry = cell_entry[g+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occ[g]),
                .left_keep   (left_keep),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .keep        (cell_keep[g]),
                .entry       (cell_entry[g])
            );
        end
    endgenerate

    // Build the result word and the new count.
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            if (req_data.command == CMD_INSERT)
            begin
                if (is_full)
                begin
                    rsp_data_next.status = ST_FULL;
                end
                else
                begin
                    count_next           = count_reg + OCC_WIDTH'(1);
                    rsp_data_next.status = ST_INSERTED;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    rsp_data_next.status = ST_EMPTY;
                end
                else
                begin
                    count_next                    = count_reg - OCC_WIDTH'(1);
                    rsp_data_next.status          = ST_SERVED;
                    rsp_data_next.served_tag      = cell_entry[0].tag;
                    rsp_data_next.served_priority = cell_entry[0].prio;
                end
            end
            rsp_data_next.occupancy = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== rtl/core/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input spq_pkg::req_word_t req_data,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input spq_pkg::rsp_word_t rsp_data
);
    import spq_pkg::*;

    // Hold a stalled result word.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result word changed or dropped");

    // Every accepted command yields a result word in the cycle after it is accepted.
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no result word after accepted command");

    // Served fields are zero unless an entry was served.
    a_served_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_SERVED) |->
            (rsp_data.served_tag == '0) && (rsp_data.served_priority == '0))
        else $error("served fields nonzero without a serve");

    // Occupancy stays within the store and matches the status.
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.occupancy <= OCC_WIDTH'(QUEUE_DEPTH)) &&
            ((rsp_data.status != ST_EMPTY) || (rsp_data.occupancy == '0)) &&
            ((rsp_data.status != ST_FULL) ||
             (rsp_data.occupancy == OCC_WIDTH'(QUEUE_DEPTH))))
        else $error("occupancy inconsistent with status");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
